// ===== hdl/ihx_pkg.sv =====
// Package for the Intel HEX record parser: item types, token and record-state
// structs, result and error codes, and the hex pair decode step.
// No dependencies; every other file of the block but the queue imports it.
package ihx_pkg;

  localparam logic [3:0] MIN_LINE  = 4'd11;
  localparam logic [8:0] COUNT_MAX = 9'd511;

  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_COLON = 8'h3a;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_COMMIT = 2'd1;
  localparam logic [1:0] KIND_EOF    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_HEX    = 3'd1;
  localparam logic [2:0] ERR_SUM    = 3'd2;
  localparam logic [2:0] ERR_LEN    = 3'd3;
  localparam logic [2:0] ERR_NO_EOF = 3'd4;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] byte_address;
    logic [7:0]  data_byte;
    logic [2:0]  error_code;
  } out_item_t;

  typedef enum logic [1:0] {
    TOK_CHAR,
    TOK_NEWLINE,
    TOK_END
  } tok_kind_t;

  // One classified character as it travels from the front to the back.
  typedef struct packed {
    tok_kind_t  kind;
    logic       is_colon;
    logic       is_cr;
    logic [3:0] nib;
    logic       nib_ok;
  } tok_t;

  typedef enum logic [1:0] {
    MODE_AWAIT,
    MODE_REC,
    MODE_SKIP
  } line_mode_t;

  typedef enum logic [1:0] {
    RUN_GO,
    RUN_EOF,
    RUN_ERR
  } run_t;

  typedef enum logic [2:0] {
    CL_NONE,
    CL_COMMIT,
    CL_EOF,
    CL_ERR_HEX,
    CL_ERR_SUM,
    CL_ERR_LEN
  } close_t;

  // Record state built up by the pair decoder over one line.
  typedef struct packed {
    logic        held_valid;
    logic [3:0]  held_nib;
    logic        held_ok;
    logic [8:0]  cnt;
    logic [7:0]  sum;
    logic [7:0]  len;
    logic [15:0] addr;
    logic [7:0]  typ;
    logic        bad;
  } rec_state_t;

  typedef struct packed {
    rec_state_t  st;
    logic        emit;
    logic [16:0] addr;
    logic [7:0]  data;
  } feed_res_t;

  // Takes one hex digit into the pair decoder. The first digit of a pair is
  // held; the second completes a record byte.
  function automatic feed_res_t feed(rec_state_t s, logic [3:0] nib, logic ok);
    feed_res_t  r;
    logic [7:0] b;
    logic       bad;
    logic [8:0] lim;
    logic [8:0] off;
    r      = '0;
    r.st   = s;
    b      = {s.held_nib, nib};
    bad    = s.bad | ~(s.held_ok & ok);
    lim    = {1'b0, s.len} + 9'd4;
    off    = s.cnt - 9'd4;
    if (!s.held_valid) begin
      r.st.held_valid = 1'b1;
      r.st.held_nib   = nib;
      r.st.held_ok    = ok;
    end else begin
      r.st.held_valid = 1'b0;
      r.st.bad        = bad;
      r.st.sum        = s.sum + b;
      if (s.cnt != COUNT_MAX) begin
        r.st.cnt = s.cnt + 9'd1;
      end
      case (s.cnt)
        9'd0: r.st.len = b;
        9'd1: r.st.addr[15:8] = b;
        9'd2: r.st.addr[7:0] = b;
        9'd3: r.st.typ = b;
        default: begin
          if (!bad && s.typ == 8'd0 && s.cnt < lim) begin
            r.emit = 1'b1;
            r.addr = {1'b0, s.addr} + {9'd0, off[7:0]};
            r.data = b;
          end
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ===== hdl/ihx_fifo.sv =====
// Small register-based queue used between the parser stages and at the output.
// Depends on nothing but its parameters.
module ihx_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

// ===== hdl/ihx_front.sv =====
// Front stage of the parser: classifies each incoming character and decodes
// its hex digit value. Depends on ihx_pkg.
module ihx_front import ihx_pkg::*; (
  input  in_item_t item,
  output tok_t     tok
);

  logic [7:0] c;

  assign c = item.char_in;

  always_comb begin
    tok          = '0;
    tok.kind     = TOK_CHAR;
    tok.is_colon = (c == CHAR_COLON);
    tok.is_cr    = (c == CHAR_CR);
    if (item.end_of_input) begin
      tok.kind = TOK_END;
    end else if (c == CHAR_NL) begin
      tok.kind = TOK_NEWLINE;
    end
    // A character that is not a hex digit decodes as zero and is flagged.
    if (c >= "0" && c <= "9") begin
      tok.nib    = 4'(c - "0");
      tok.nib_ok = 1'b1;
    end else if (c >= "A" && c <= "F") begin
      tok.nib    = 4'(c - "A" + 8'd10);
      tok.nib_ok = 1'b1;
    end else if (c >= "a" && c <= "f") begin
      tok.nib    = 4'(c - "a" + 8'd10);
      tok.nib_ok = 1'b1;
    end
  end

endmodule

// ===== hdl/ihx_back.sv =====
// Back stage of the parser: line tracking, pair decoding, record checks and
// result generation, one token per cycle while the result queue is not full. Depends on ihx_pkg.
module ihx_back import ihx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tok_t      tok,
  input  logic      tok_valid,
  output logic      tok_pop,
  input  logic      res_full,
  output logic      res_push,
  output out_item_t res
);

  logic [3:0] lcnt_r, lcnt_nxt;
  line_mode_t mode_r, mode_nxt;
  logic       cr_r, cr_nxt;
  rec_state_t rec_r, rec_nxt;
  run_t       run_r, run_nxt;

  logic       step;
  close_t     cl;
  feed_res_t  f_cr, f_ch;
  rec_state_t s1;
  logic       data_emit;

  assign tok_pop = tok_valid & ~res_full;
  // Once halted, tokens are still drained but have no effect.
  assign step    = tok_pop & (run_r == RUN_GO);

  always_comb begin
    cl = CL_NONE;
    if (mode_r == MODE_REC && lcnt_r == MIN_LINE) begin
      if (rec_r.bad) begin
        cl = CL_ERR_HEX;
      end else if (rec_r.sum != 8'd0) begin
        cl = CL_ERR_SUM;
      end else if ({1'b0, rec_r.len} + 9'd5 != rec_r.cnt) begin
        cl = CL_ERR_LEN;
      end else if (rec_r.typ == 8'd0) begin
        cl = CL_COMMIT;
      end else if (rec_r.typ == 8'd1) begin
        cl = CL_EOF;
      end
    end
  end

  // A CR that turned out not to end the line is fed as a bad digit first.
  // That feed can never emit a data byte, so only the second one can.
  always_comb begin
    f_cr = feed(rec_r, 4'd0, 1'b0);
    s1   = cr_r ? f_cr.st : rec_r;
    f_ch = feed(s1, tok.nib, tok.nib_ok);
  end

  always_comb begin
    lcnt_nxt  = lcnt_r;
    mode_nxt  = mode_r;
    cr_nxt    = cr_r;
    rec_nxt   = rec_r;
    data_emit = 1'b0;
    if (step) begin
      if (tok.kind != TOK_CHAR) begin
        lcnt_nxt = '0;
        mode_nxt = MODE_AWAIT;
        cr_nxt   = 1'b0;
        rec_nxt  = '0;
      end else begin
        cr_nxt  = 1'b0;
        rec_nxt = s1;
        if (lcnt_r < MIN_LINE) begin
          lcnt_nxt = lcnt_r + 4'd1;
        end
        unique case (mode_r)
          MODE_AWAIT: mode_nxt = tok.is_colon ? MODE_REC : MODE_SKIP;
          MODE_REC: begin
            if (tok.is_cr) begin
              cr_nxt = 1'b1;
            end else begin
              rec_nxt   = f_ch.st;
              data_emit = f_ch.emit;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    run_nxt = run_r;
    unique case (run_r)
      RUN_GO: begin
        if (step && tok.kind == TOK_END) begin
          run_nxt = (cl == CL_EOF) ? RUN_EOF : RUN_ERR;
        end else if (step && tok.kind == TOK_NEWLINE) begin
          if (cl == CL_EOF) begin
            run_nxt = RUN_EOF;
          end else if (cl == CL_ERR_HEX || cl == CL_ERR_SUM || cl == CL_ERR_LEN) begin
            run_nxt = RUN_ERR;
          end
        end
      end
      RUN_EOF: run_nxt = RUN_EOF;
      RUN_ERR: run_nxt = RUN_ERR;
      default: run_nxt = RUN_ERR;
    endcase
  end

  always_comb begin
    res      = '0;
    res_push = 1'b0;
    if (step) begin
      case (tok.kind)
        TOK_CHAR: begin
          if (data_emit) begin
            res_push         = 1'b1;
            res.kind         = KIND_DATA;
            res.byte_address = f_ch.addr;
            res.data_byte    = f_ch.data;
          end
        end
        default: begin
          unique case (cl)
            CL_COMMIT: begin
              // A good data record at end of input still lacks the EOF record.
              res_push = 1'b1;
              if (tok.kind == TOK_END) begin
                res.kind       = KIND_ERROR;
                res.error_code = ERR_NO_EOF;
              end else begin
                res.kind = KIND_COMMIT;
              end
            end
            CL_EOF: begin
              res_push = 1'b1;
              res.kind = KIND_EOF;
            end
            CL_ERR_HEX: begin
              res_push       = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_HEX;
            end
            CL_ERR_SUM: begin
              res_push       = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_SUM;
            end
            CL_ERR_LEN: begin
              res_push       = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_LEN;
            end
            default: begin
              if (tok.kind == TOK_END) begin
                res_push       = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_NO_EOF;
              end
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcnt_r <= '0;
      mode_r <= MODE_AWAIT;
      cr_r   <= 1'b0;
      rec_r  <= '0;
      run_r  <= RUN_GO;
    end else begin
      lcnt_r <= lcnt_nxt;
      mode_r <= mode_nxt;
      cr_r   <= cr_nxt;
      rec_r  <= rec_nxt;
      run_r  <= run_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r != RUN_GO) |-> !res_push)
    else $error("result produced after the parser halted");

  a_push_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (tok_pop && !res_full))
    else $error("result produced without consuming a token");

  a_held_in_record: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_r.held_valid || cr_r) |-> (mode_r == MODE_REC))
    else $error("held digit or pending CR outside a record line");

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r != RUN_GO) |=> $stable(run_r))
    else $error("halted parser resumed");
`endif

endmodule

// ===== hdl/intel_hex_record_parser_unit.sv =====
// Top level of the Intel HEX record parser: front classifier, token queue,
// back record engine and result queue. Depends on ihx_pkg and its submodules.
//
//   channel   ports                      handshake
//   input     push, full, in_data        accepted when push && !full
//   result    empty, pop, out_data       accepted when pop && !empty
//
// One character is taken per cycle while full is low; the back engine finishes a token in the
// cycle it leaves the token queue, so a result reaches the result ports through the token
// queue register and then the result queue register. Reset is synchronous.
// A stalled result side fills the result queue, then the token queue, and
// only then raises full; input gaps drain both queues without loss.
module intel_hex_record_parser_unit import ihx_pkg::*; #(
  parameter int QUEUE_DEPTH = 2,
  parameter int OUT_DEPTH   = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  in_item_t  in_data,
  output logic      full,
  input  logic      pop,
  output out_item_t out_data,
  output logic      empty
);

  localparam int TW = $bits(tok_t);
  localparam int OW = $bits(out_item_t);

  tok_t          tok_in, tok_out;
  logic [TW-1:0] tok_q;
  logic          tok_empty, tok_pop;
  logic          res_full, res_push;
  out_item_t     res;
  logic [OW-1:0] res_q;

  ihx_front u_front (
    .item (in_data),
    .tok  (tok_in)
  );

  ihx_fifo #(
    .WIDTH (TW),
    .DEPTH (QUEUE_DEPTH)
  ) u_tok_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (TW'(tok_in)),
    .full  (full),
    .pop   (tok_pop),
    .dout  (tok_q),
    .empty (tok_empty)
  );

  assign tok_out = tok_t'(tok_q);

  ihx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok       (tok_out),
    .tok_valid (~tok_empty),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  ihx_fifo #(
    .WIDTH (OW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (OW'(res)),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_q),
    .empty (empty)
  );

  assign out_data = out_item_t'(res_q);

endmodule

// ===== tb/sv/intel_hex_record_parser_unit_tb.sv =====
// Self-checking testbench for intel_hex_record_parser_unit: feeds Intel HEX text one
// character per request and checks every result against an in-bench predictor.
// Depends on ihx_pkg for the item structs and the kind and error codes.
module intel_hex_record_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ihx_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_CHARS = 340;
  localparam int DRAIN_CYCLES = 16;
  localparam int DIR_ROWS     = 12;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      push    = 1'b0;
  in_item_t  in_data = '0;
  logic      full;
  logic      pop     = 1'b0;
  out_item_t out_data;
  logic      empty;

  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned cycle_cnt     = 0;
  int          mismatches    = 0;

  out_item_t  results_due[$];
  out_item_t  head_result;
  logic [7:0] text_q[$];

  // Line and record state of the predictor.
  logic [3:0]  ln_chars;
  line_mode_t  ln_mode;
  logic [7:0]  pair_hi;
  logic        pair_hi_v;
  logic        cr_held;
  logic [8:0]  rec_bytes;
  logic [7:0]  rec_sum;
  logic [7:0]  rec_len;
  logic [15:0] rec_addr;
  logic [7:0]  rec_type;
  logic        rec_bad;
  run_t        parser_run;

  string     dir_line [DIR_ROWS];
  bit        dir_typed[DIR_ROWS];
  out_item_t dir_close[DIR_ROWS];

  intel_hex_record_parser_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .pop      (pop),
    .out_data (out_data),
    .empty    (empty)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The upper bit tells whether the character is a hex digit.
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic out_item_t result_of(logic [1:0] kind, logic [2:0] err);
    out_item_t r;
    r            = '0;
    r.kind       = kind;
    r.error_code = err;
    return r;
  endfunction

  function automatic void add_text(logic [7:0] c);
    text_q = {text_q, c};
  endfunction

  function automatic void add_due(out_item_t r);
    results_due = {results_due, r};
  endfunction

  function automatic void take_digit(logic [7:0] c);
    logic [4:0] hi;
    logic [4:0] lo;
    logic [7:0] b;
    int         idx;
    out_item_t  r;
    if (!pair_hi_v) begin
      pair_hi   = c;
      pair_hi_v = 1'b1;
      return;
    end
    pair_hi_v = 1'b0;
    hi        = hex_nibble(pair_hi);
    lo        = hex_nibble(c);
    b         = {hi[3:0], lo[3:0]};
    if (!(hi[4] && lo[4])) rec_bad = 1'b1;
    idx = int'(rec_bytes);
    if (rec_bytes != COUNT_MAX) rec_bytes = rec_bytes + 9'd1;
    rec_sum = rec_sum + b;
    case (idx)
      0: rec_len = b;
      1: rec_addr[15:8] = b;
      2: rec_addr[7:0] = b;
      3: rec_type = b;
      default: begin
        // Data bytes go out as soon as they are decoded, before the line is checked.
        if (!rec_bad && rec_type == 8'd0 && idx < 4 + int'(rec_len)) begin
          r              = '0;
          r.kind         = KIND_DATA;
          r.byte_address = 17'(int'(rec_addr) + idx - 4);
          r.data_byte    = b;
          add_due(r);
        end
      end
    endcase
  endfunction

  function automatic void clear_record();
    ln_chars  = '0;
    ln_mode   = MODE_AWAIT;
    pair_hi   = '0;
    pair_hi_v = 1'b0;
    cr_held   = 1'b0;
    rec_bytes = '0;
    rec_sum   = '0;
    rec_len   = '0;
    rec_addr  = '0;
    rec_type  = '0;
    rec_bad   = 1'b0;
  endfunction

  function automatic close_t close_record();
    close_t cl;
    cl = CL_NONE;
    if (ln_mode == MODE_REC && ln_chars >= MIN_LINE) begin
      if (rec_bad) cl = CL_ERR_HEX;
      else if (rec_sum != 8'd0) cl = CL_ERR_SUM;
      else if ({1'b0, rec_len} + 9'd5 != rec_bytes) cl = CL_ERR_LEN;
      else if (rec_type == 8'd0) cl = CL_COMMIT;
      else if (rec_type == 8'd1) cl = CL_EOF;
    end
    clear_record();
    case (cl)
      CL_EOF: parser_run = RUN_EOF;
      CL_ERR_HEX, CL_ERR_SUM, CL_ERR_LEN: parser_run = RUN_ERR;
      default: ;
    endcase
    return cl;
  endfunction

  function automatic void parse_char(in_item_t it);
    close_t     cl;
    logic [7:0] c;
    c = it.char_in;
    if (parser_run != RUN_GO) return;
    if (it.end_of_input || c == CHAR_NL) begin
      cl = close_record();
      case (cl)
        CL_COMMIT: begin
          if (!it.end_of_input) add_due(result_of(KIND_COMMIT, ERR_NONE));
        end
        CL_EOF:     add_due(result_of(KIND_EOF, ERR_NONE));
        CL_ERR_HEX: add_due(result_of(KIND_ERROR, ERR_HEX));
        CL_ERR_SUM: add_due(result_of(KIND_ERROR, ERR_SUM));
        CL_ERR_LEN: add_due(result_of(KIND_ERROR, ERR_LEN));
        default: ;
      endcase
      // End of text without a closing EOF record stops the parser with an error.
      if (it.end_of_input && parser_run == RUN_GO) begin
        parser_run = RUN_ERR;
        add_due(result_of(KIND_ERROR, ERR_NO_EOF));
      end
      return;
    end
    // A CR that turns out not to end the line counts as a bad (non-hex) digit.
    if (cr_held) begin
      cr_held = 1'b0;
      take_digit(CHAR_CR);
    end
    if (ln_chars < MIN_LINE) ln_chars = ln_chars + 4'd1;
    case (ln_mode)
      MODE_AWAIT: ln_mode = (c == CHAR_COLON) ? MODE_REC : MODE_SKIP;
      MODE_REC: begin
        if (c == CHAR_CR) cr_held = 1'b1;
        else take_digit(c);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return ($urandom_range(1) ? "A" : "a") + 8'(n) - 8'd10;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    add_text(hex_char(b[7:4]));
    add_text(hex_char(b[3:0]));
  endfunction

  function automatic logic [7:0] any_but_nl();
    logic [7:0] c;
    c = 8'($urandom_range(254));
    if (c >= CHAR_NL) c = c + 8'd1;
    return c;
  endfunction

  function automatic void end_line(bit with_cr);
    if (with_cr) add_text(CHAR_CR);
    add_text(CHAR_NL);
  endfunction

  // Builds a record whose length field may differ from the data actually sent;
  // sum_skew is added to the correct checksum.
  function automatic void put_record(int len_field, int n_data, logic [15:0] addr,
                                     logic [7:0] typ, logic [7:0] sum_skew);
    logic [7:0] sum;
    logic [7:0] b;
    add_text(CHAR_COLON);
    sum = 8'(len_field) + addr[15:8] + addr[7:0] + typ;
    put_byte(8'(len_field));
    put_byte(addr[15:8]);
    put_byte(addr[7:0]);
    put_byte(typ);
    for (int i = 0; i < n_data; i++) begin
      b   = 8'($urandom_range(255));
      sum = sum + b;
      put_byte(b);
    end
    put_byte(8'd0 - sum + sum_skew);
  endfunction

  function automatic logic [15:0] any_addr();
    if ($urandom_range(3) == 0) return 16'hFFFF - 16'($urandom_range(40));
    return 16'($urandom_range(65535));
  endfunction

  function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_item(in_item_t it, bit has_typed, out_item_t typed);
    int unsigned due_before;
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push    = 1'b1;
    in_data = it;
    @(posedge clk);
    while (full) @(posedge clk);
    due_before = results_due.size();
    parse_char(it);
    if (has_typed) begin
      if (results_due.size() > due_before) results_due.delete(results_due.size() - 1);
      add_due(typed);
    end
    @(negedge clk);
  endtask

  task automatic send_text(bit has_typed, out_item_t typed);
    in_item_t it;
    while (text_q.size() != 0) begin
      it.char_in      = text_q.pop_front();
      it.end_of_input = 1'b0;
      send_item(it, has_typed && text_q.size() == 0, typed);
    end
  endtask

  always @(negedge clk) begin
    pop = ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (results_due.size() == 0) begin
        $error("result with nothing expected: kind %0d, error_code %0d",
               out_data.kind, out_data.error_code);
        mismatches++;
      end else begin
        head_result = results_due.pop_front();
        check_field("kind", 17'(head_result.kind), 17'(out_data.kind));
        check_field("byte_address", head_result.byte_address, out_data.byte_address);
        check_field("data_byte", 17'(head_result.data_byte), 17'(out_data.data_byte));
        check_field("error_code", 17'(head_result.error_code), 17'(out_data.error_code));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    string       row;
    in_item_t    it;
    int unsigned pick;
    int unsigned len;
    int unsigned chars_sent;
    int unsigned k;
    logic [7:0]  bad;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;

    clear_record();
    parser_run = RUN_GO;

    dir_line[0]  = "\n";
    dir_line[1]  = "\r\n";
    dir_line[2]  = "skip: not a record line\n";
    dir_line[3]  = ":0000000\r\n";
    dir_line[4]  = ":GG\n";
    dir_line[5]  = ":0000000000\n";
    dir_line[6]  = ":01FFFF00AB56\n";
    dir_line[7]  = ":03000200ABcdEf94\r\n";
    dir_line[8]  = ":00000005FB\n";
    dir_line[9]  = ":000000FF01\r\n";
    dir_line[10] = ":0000000000Z\n";
    dir_line[11] = "::\r:\r\n";
    dir_typed[5]  = 1'b1;
    dir_close[5]  = result_of(KIND_COMMIT, ERR_NONE);
    dir_typed[6]  = 1'b1;
    dir_close[6]  = result_of(KIND_COMMIT, ERR_NONE);
    dir_typed[10] = 1'b1;
    dir_close[10] = result_of(KIND_COMMIT, ERR_NONE);

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_line[i];
      for (int j = 0; j < row.len(); j++) add_text(row[j]);
      send_text(dir_typed[i], dir_close[i]);
    end
    // Longest record at the top of the address space reaches the highest byte address.
    put_record(255, 255, 16'hFFFF, 8'h00, 8'h00);
    end_line(1'b1);
    send_text(1'b0, '0);

    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      case (chars_sent * 4 / RANDOM_CHARS)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 74; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 74; end
        default: begin send_idle_pct = 27; pop_stall_pct = 27; end
      endcase
      pick = $urandom_range(99);
      if (pick < 60) begin
        k = $urandom_range(99);
        if (k < 80) len = $urandom_range(16);
        else len = $urandom_range(48, 17);
        put_record(len, len, any_addr(), 8'h00, 8'h00);
        // An unpaired last character is dropped without a check.
        if ($urandom_range(9) == 0) add_text(any_but_nl());
        end_line($urandom_range(1));
      end else if (pick < 72) begin
        len = $urandom_range(8);
        put_record(len, len, any_addr(), 8'($urandom_range(255, 2)), 8'h00);
        end_line($urandom_range(1));
      end else if (pick < 84) begin
        bad = any_but_nl();
        if (bad == CHAR_COLON) bad = "#";
        add_text(bad);
        repeat ($urandom_range(40)) add_text(any_but_nl());
        end_line(1'b0);
      end else if (pick < 94) begin
        add_text(CHAR_COLON);
        repeat ($urandom_range(9)) add_text(any_but_nl());
        end_line(1'b0);
      end else begin
        end_line($urandom_range(1));
      end
      chars_sent += text_q.size();
      send_text(1'b0, '0);
    end

    // The parser halts for good on EOF or an error, so only one closing case fits in a run.
    len = $urandom_range(6);
    case ($urandom_range(6))
      0: begin
        put_record(len, len, any_addr(), 8'h01, 8'h00);
        end_line($urandom_range(1));
      end
      1: begin
        put_record(len, len, any_addr(), 8'h00, 8'h00);
        bad = any_but_nl();
        while (hex_nibble(bad) >= 5'h10) bad = any_but_nl();
        if ($urandom_range(1)) bad = CHAR_CR;
        k = $urandom_range(text_q.size() - 1, 1);
        text_q[k] = bad;
        end_line($urandom_range(1));
      end
      2: begin
        put_record(len, len, any_addr(), 8'h00, 8'($urandom_range(255, 1)));
        end_line($urandom_range(1));
      end
      3: begin
        put_record(len, len + 1 + $urandom_range(2), any_addr(), 8'h00, 8'h00);
        end_line($urandom_range(1));
      end
      4: begin
        // Eleven characters with a final CR leave only the four header bytes.
        b0 = 8'($urandom_range(255));
        b1 = 8'($urandom_range(255));
        b2 = 8'($urandom_range(255));
        add_text(CHAR_COLON);
        put_byte(b0);
        put_byte(b1);
        put_byte(b2);
        put_byte(8'd0 - b0 - b1 - b2);
        add_text(hex_char(4'($urandom_range(15))));
        end_line(1'b1);
      end
      5: begin
        put_record(len, len, any_addr(), 8'h00, 8'h00);
        end_line($urandom_range(1));
      end
      default: begin
        put_record(len, len, any_addr(), 8'h01, 8'h00);
        if ($urandom_range(1)) add_text(CHAR_CR);
      end
    endcase
    send_text(1'b0, '0);
    it.char_in      = 8'($urandom_range(255));
    it.end_of_input = 1'b1;
    send_item(it, 1'b0, '0);
    // Everything after the halt must be ignored.
    repeat (8) begin
      it.char_in      = 8'($urandom_range(255));
      it.end_of_input = $urandom_range(1);
      send_item(it, 1'b0, '0);
    end
    push = 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
